FILE: hw/rtl/tapc_pkg.sv
// ----------------------------------------------------------------------------
// Throttle actuator position control package
// Shared widths, constants, register indexes, state and command types.
// ----------------------------------------------------------------------------
package tapc_pkg;

    // Field widths
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CMD_W      = 16;
    localparam int unsigned ADC_W      = 10;
    localparam int unsigned POS_W      = 22;
    localparam int unsigned PWM_W      = 8;
    localparam int unsigned REF_W      = 12;
    localparam int unsigned GRACE_W    = 16;
    localparam int unsigned DIR_W      = 2;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PWM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MIN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MAX  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE_MS     = 3'd7;

    // Register values after reset
    localparam logic [POS_W-1:0]   RST_DEADBAND     = 22'd25;
    localparam logic [POS_W-1:0]   RST_POSITION_MIN = 22'd20;
    localparam logic [POS_W-1:0]   RST_POSITION_MAX = 22'd2300;
    localparam logic [PWM_W-1:0]   RST_SLOW_PWM     = 8'd200;
    localparam logic [REF_W-1:0]   RST_REFERENCE    = 12'd1000;
    localparam logic [CMD_W-1:0]   RST_COMMAND_MIN  = 16'd477;
    localparam logic [CMD_W-1:0]   RST_COMMAND_MAX  = 16'd1430;
    localparam logic [GRACE_W-1:0] RST_GRACE_MS     = 16'd500;

    // Control constants
    localparam logic [PWM_W-1:0]  FULL_PWM         = 8'd255;
    localparam logic [POS_W-1:0]  SLOW_LIMIT       = 22'd100;
    localparam logic [TIME_W-1:0] FRAME_TIMEOUT_MS = 32'd500;
    localparam logic [ADC_W:0]    ADC_FULL         = 11'd1024;

    // Samples
    localparam int unsigned NUM_SAMPLES = 5;
    localparam int unsigned SMP_IDX_W   = 3;
    localparam logic [SMP_IDX_W-1:0] LAST_SAMPLE = 3'd4;
    localparam int unsigned NUM_W       = REF_W + ADC_W + 1;

    // Shared divider: four quotient bits per cycle
    localparam int unsigned DIV_W         = 40;
    localparam int unsigned DIVISOR_W     = 16;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned DIV_CNT_W     = 4;
    localparam int unsigned SAMPLE_DIGITS = 6;
    localparam int unsigned TARGET_DIGITS = 10;
    localparam int unsigned SMP_SHIFT     = DIV_W - DIGIT_W * SAMPLE_DIGITS;

    // Target span product
    localparam int unsigned PROD_W = CMD_W + POS_W;

    // Mean of five by reciprocal multiplication
    localparam int unsigned SUM_W       = 25;
    localparam int unsigned RECIP_W     = 32;
    localparam int unsigned MEAN_PROD_W = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned MEAN_SHIFT  = 34;

    // Motor direction codes
    typedef enum logic [DIR_W-1:0] {
        DIR_OFF     = 2'd0,
        DIR_PULL    = 2'd1,
        DIR_RELEASE = 2'd2
    } dir_t;

    // Configuration register set
    typedef struct packed {
        logic [POS_W-1:0]   deadband;
        logic [POS_W-1:0]   position_min;
        logic [POS_W-1:0]   position_max;
        logic [PWM_W-1:0]   slow_pwm;
        logic [REF_W-1:0]   reference_ohms;
        logic [CMD_W-1:0]   command_min;
        logic [CMD_W-1:0]   command_max;
        logic [GRACE_W-1:0] grace_ms;
    } tapc_cfg_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_SMP_START,
        ST_SMP_WAIT,
        ST_MEAN,
        ST_TGT_START,
        ST_TGT_WAIT,
        ST_TGT,
        ST_DECIDE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                 capture;
        logic                 prep;
        logic                 mul;
        logic                 smp_start;
        logic [SMP_IDX_W-1:0] smp_idx;
        logic                 acc_add;
        logic                 mean;
        logic                 tgt_start;
        logic                 tgt;
        logic                 decide;
    } tapc_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_busy;
        logic out_free;
    } tapc_stat_t;

endpackage

FILE: hw/rtl/tapc_div.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned division producing four quotient bits per cycle. The dividend
// is left aligned by the caller so that the requested digit count covers it.
// ----------------------------------------------------------------------------
module tapc_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tapc_pkg::DIV_CNT_W-1:0] digits,
    input  logic [tapc_pkg::DIV_W-1:0]     dividend,
    input  logic [tapc_pkg::DIVISOR_W-1:0] divisor,
    output logic                           busy,
    output logic [tapc_pkg::DIV_W-1:0]     quotient
);
    import tapc_pkg::*;

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     sh_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;

    logic [DIV_W-1:0]     sh_next;
    logic [DIVISOR_W-1:0] rem_next;
    logic [DIVISOR_W:0]   trial;

    // One digit: four shift-and-subtract steps.
    always_comb
    begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            trial   = {rem_next, sh_next[DIV_W-1]};
            sh_next = {sh_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial      = trial - {1'b0, dvs_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    // Control: busy flag and digit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= digits;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = sh_reg;

endmodule

FILE: hw/rtl/tapc_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register set addressed by index.
// ----------------------------------------------------------------------------
module tapc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tapc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tapc_pkg::tapc_cfg_t             cfg
);
    import tapc_pkg::*;

    tapc_cfg_t cfg_reg;

    // Each write lands in the register picked by the index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband       <= RST_DEADBAND;
            cfg_reg.position_min   <= RST_POSITION_MIN;
            cfg_reg.position_max   <= RST_POSITION_MAX;
            cfg_reg.slow_pwm       <= RST_SLOW_PWM;
            cfg_reg.reference_ohms <= RST_REFERENCE;
            cfg_reg.command_min    <= RST_COMMAND_MIN;
            cfg_reg.command_max    <= RST_COMMAND_MAX;
            cfg_reg.grace_ms       <= RST_GRACE_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEADBAND:     cfg_reg.deadband       <= cfg_data[POS_W-1:0];
                REG_POSITION_MIN: cfg_reg.position_min   <= cfg_data[POS_W-1:0];
                REG_POSITION_MAX: cfg_reg.position_max   <= cfg_data[POS_W-1:0];
                REG_SLOW_PWM:     cfg_reg.slow_pwm       <= cfg_data[PWM_W-1:0];
                REG_REFERENCE:    cfg_reg.reference_ohms <= cfg_data[REF_W-1:0];
                REG_COMMAND_MIN:  cfg_reg.command_min    <= cfg_data[CMD_W-1:0];
                REG_COMMAND_MAX:  cfg_reg.command_max    <= cfg_data[CMD_W-1:0];
                REG_GRACE_MS:     cfg_reg.grace_ms       <= cfg_data[GRACE_W-1:0];
                default:          cfg_reg                <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/tapc_datapath.sv
// ----------------------------------------------------------------------------
// Throttle actuator datapath
// Input capture, cancel logic, resistance conversion, averaging, target
// scaling, motor decision and the output register.
// ----------------------------------------------------------------------------
module tapc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tapc_pkg::tapc_cmd_t            cmd,
    output tapc_pkg::tapc_stat_t           stat,
    input  tapc_pkg::tapc_cfg_t            cfg,
    input  logic [tapc_pkg::TIME_W-1:0]    now_ms,
    input  logic                           clutch_pressed,
    input  logic                           brake_pressed,
    input  logic                           frame_valid,
    input  logic [tapc_pkg::CMD_W-1:0]     frame_command,
    input  logic [tapc_pkg::ADC_W-1:0]     adc_a,
    input  logic [tapc_pkg::ADC_W-1:0]     adc_b,
    input  logic [tapc_pkg::ADC_W-1:0]     adc_c,
    input  logic [tapc_pkg::ADC_W-1:0]     adc_d,
    input  logic [tapc_pkg::ADC_W-1:0]     adc_e,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           solenoid_closed,
    output logic [tapc_pkg::DIR_W-1:0]     motor_direction,
    output logic [tapc_pkg::PWM_W-1:0]     motor_pwm,
    output logic                           cancelled,
    output logic [tapc_pkg::POS_W-1:0]     position,
    output logic [tapc_pkg::POS_W-1:0]     target
);
    import tapc_pkg::*;

    // Captured item
    logic [TIME_W-1:0] now_reg;
    logic              clutch_reg;
    logic              brake_reg;
    logic              frame_reg;
    logic [CMD_W-1:0]  fcmd_reg;
    logic [ADC_W-1:0]  adc_reg [NUM_SAMPLES];

    // State kept across items
    logic [TIME_W-1:0] last_frame_reg;
    logic [TIME_W-1:0] last_clutch_reg;
    logic [CMD_W-1:0]  held_cmd_reg;
    dir_t              held_dir_reg;

    // Per-item working registers
    logic                   cancel_reg;
    logic                   raw_zero_reg;
    logic [SUM_W-1:0]       acc_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [MEAN_PROD_W-1:0] mean_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       tgt_reg;

    // Output register
    logic              out_valid_reg;
    logic              sol_out_reg;
    dir_t              dir_out_reg;
    logic [PWM_W-1:0]  pwm_out_reg;
    logic              cancel_out_reg;
    logic [POS_W-1:0]  pos_out_reg;
    logic [POS_W-1:0]  tgt_out_reg;

    // Combinational intermediates
    logic [TIME_W-1:0]    age_clutch;
    logic [TIME_W-1:0]    age_frame;
    logic                 cancel_next;
    logic [CMD_W-1:0]     cmd_clamped;
    logic [CMD_W-1:0]     cmd_offset;
    logic [POS_W-1:0]     pos_span;
    logic [PROD_W-1:0]    span_prod;
    logic [ADC_W-1:0]     raw;
    logic [NUM_W-1:0]     smp_num;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic [DIV_CNT_W-1:0] div_digits;
    logic                 div_start;
    logic                 div_busy;
    logic [DIV_W-1:0]     div_quot;
    logic [SUM_W-1:0]     smp_ohms;
    logic [DIV_W:0]       tgt_sum;
    logic [POS_W-1:0]     tgt_next;
    logic [POS_W-1:0]     err;
    logic                 drive;
    logic [PWM_W-1:0]     pwm_sel;
    dir_t                 dir_next;
    logic [PWM_W-1:0]     pwm_next;
    logic                 out_free;

    // Cancel conditions; the frame age uses the time of the previous frame.
    assign age_clutch  = now_reg - last_clutch_reg;
    assign age_frame   = now_reg - last_frame_reg;
    assign cancel_next = clutch_reg || brake_reg
                      || (age_clutch < TIME_W'(cfg.grace_ms))
                      || (age_frame > FRAME_TIMEOUT_MS)
                      || (now_reg < last_frame_reg);

    // Command clamp and span product for the target scaling.
    assign cmd_clamped = (held_cmd_reg >= cfg.command_min) ? held_cmd_reg : cfg.command_min;
    assign cmd_offset  = cmd_clamped - cfg.command_min;
    assign pos_span    = cfg.position_max - cfg.position_min;
    assign span_prod   = PROD_W'(cmd_offset) * PROD_W'(pos_span);

    // Sample numerator: reference * (1024 - raw).
    assign raw     = adc_reg[cmd.smp_idx];
    assign smp_num = NUM_W'(cfg.reference_ohms) * NUM_W'(ADC_FULL - {1'b0, raw});

    // Divider operand selection: a sample or the target span.
    always_comb
    begin
        div_start = cmd.smp_start || cmd.tgt_start;
        if (cmd.tgt_start)
        begin
            div_dividend = DIV_W'(prod_reg);
            div_divisor  = cfg.command_max - cfg.command_min;
            div_digits   = DIV_CNT_W'(TARGET_DIGITS);
        end
        else
        begin
            div_dividend = DIV_W'(smp_num) << SMP_SHIFT;
            div_divisor  = DIVISOR_W'(raw);
            div_digits   = DIV_CNT_W'(SAMPLE_DIGITS);
        end
    end

    tapc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .digits   (div_digits),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // A zero sample reads as zero ohms.
    assign smp_ohms = raw_zero_reg ? '0 : SUM_W'(div_quot[POS_W-1:0]);

    // Target with the empty span and inverted range cases, then saturation.
    assign tgt_sum = (DIV_W+1)'(cfg.position_min) + {1'b0, div_quot};
    always_comb
    begin
        if (cfg.position_max < cfg.position_min)
        begin
            tgt_next = cfg.position_min;
        end
        else if (cfg.command_max <= cfg.command_min)
        begin
            tgt_next = (held_cmd_reg <= cfg.command_min) ? cfg.position_min
                                                         : cfg.position_max;
        end
        else if (tgt_sum > (DIV_W+1)'(cfg.position_max))
        begin
            tgt_next = cfg.position_max;
        end
        else
        begin
            tgt_next = tgt_sum[POS_W-1:0];
        end
    end

    // Motor decision: drive outside the deadband, never past an end point.
    assign err     = (pos_reg >= tgt_reg) ? pos_reg - tgt_reg : tgt_reg - pos_reg;
    assign drive   = !cancel_reg && (err >= cfg.deadband);
    assign pwm_sel = (err > SLOW_LIMIT) ? FULL_PWM : cfg.slow_pwm;
    always_comb
    begin
        dir_next = held_dir_reg;
        pwm_next = '0;
        if (drive)
        begin
            if ((pos_reg < tgt_reg) && (pos_reg < cfg.position_max))
            begin
                dir_next = DIR_PULL;
                pwm_next = pwm_sel;
            end
            else if ((pos_reg > tgt_reg) && (pos_reg > cfg.position_min))
            begin
                dir_next = DIR_RELEASE;
                pwm_next = pwm_sel;
            end
        end
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg    <= now_ms;
            clutch_reg <= clutch_pressed;
            brake_reg  <= brake_pressed;
            frame_reg  <= frame_valid;
            fcmd_reg   <= frame_command;
            adc_reg[0] <= adc_a;
            adc_reg[1] <= adc_b;
            adc_reg[2] <= adc_c;
            adc_reg[3] <= adc_d;
            adc_reg[4] <= adc_e;
        end
    end

    // State carried from item to item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_frame_reg  <= '0;
            last_clutch_reg <= '0;
            held_cmd_reg    <= '0;
            held_dir_reg    <= DIR_OFF;
        end
        else
        begin
            if (cmd.prep && clutch_reg)
            begin
                last_clutch_reg <= now_reg;
            end
            if (cmd.prep && frame_reg)
            begin
                last_frame_reg <= now_reg;
                held_cmd_reg   <= fcmd_reg;
            end
            if (cmd.decide)
            begin
                held_dir_reg <= dir_next;
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            cancel_reg <= cancel_next;
            acc_reg    <= '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= span_prod;
        end
        if (cmd.smp_start)
        begin
            raw_zero_reg <= (raw == '0);
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + smp_ohms;
        end
        if (cmd.mean)
        begin
            mean_reg <= MEAN_PROD_W'(acc_reg) * MEAN_PROD_W'(MEAN_RECIP);
        end
        if (cmd.tgt_start)
        begin
            pos_reg <= mean_reg[MEAN_SHIFT +: POS_W];
        end
        if (cmd.tgt)
        begin
            tgt_reg <= tgt_next;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.decide)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            sol_out_reg    <= !cancel_reg;
            dir_out_reg    <= dir_next;
            pwm_out_reg    <= pwm_next;
            cancel_out_reg <= cancel_reg;
            pos_out_reg    <= pos_reg;
            tgt_out_reg    <= tgt_reg;
        end
    end

    assign out_free      = !out_valid_reg || !out_stall;
    assign stat.div_busy = div_busy;
    assign stat.out_free = out_free;

    assign out_valid       = out_valid_reg;
    assign solenoid_closed = sol_out_reg;
    assign motor_direction = dir_out_reg;
    assign motor_pwm       = pwm_out_reg;
    assign cancelled       = cancel_out_reg;
    assign position        = pos_out_reg;
    assign target          = tgt_out_reg;

endmodule

FILE: hw/rtl/tapc_ctrl.sv
// ----------------------------------------------------------------------------
// Throttle actuator controller
// Sequences one item through capture, sample divisions, averaging, target
// division and the motor decision.
// ----------------------------------------------------------------------------
module tapc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output tapc_pkg::tapc_cmd_t  cmd,
    input  tapc_pkg::tapc_stat_t stat
);
    import tapc_pkg::*;

    state_t               state_reg;
    state_t               state_next;
    logic [SMP_IDX_W-1:0] smp_reg;
    logic [SMP_IDX_W-1:0] smp_next;

    // State and sample counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            smp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            smp_reg   <= smp_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        smp_next    = smp_reg;
        cmd         = '0;
        cmd.smp_idx = smp_reg;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                smp_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SMP_START;
            end
            ST_SMP_START:
            begin
                cmd.smp_start = 1'b1;
                state_next    = ST_SMP_WAIT;
            end
            ST_SMP_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    cmd.acc_add = 1'b1;
                    if (smp_reg == LAST_SAMPLE)
                    begin
                        state_next = ST_MEAN;
                    end
                    else
                    begin
                        smp_next   = smp_reg + 1'b1;
                        state_next = ST_SMP_START;
                    end
                end
            end
            ST_MEAN:
            begin
                cmd.mean   = 1'b1;
                state_next = ST_TGT_START;
            end
            ST_TGT_START:
            begin
                cmd.tgt_start = 1'b1;
                state_next    = ST_TGT_WAIT;
            end
            ST_TGT_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_TGT;
                end
            end
            ST_TGT:
            begin
                cmd.tgt    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/throttle_actuator_position_control.sv
// ----------------------------------------------------------------------------
// Throttle actuator position control
// Bang-bang positioning of a throttle actuator with a deadband.
// ----------------------------------------------------------------------------
// The block takes one control tick per item and returns one result item.
// A new item can be accepted in the cycle after the result of the last
// one is registered, so the block handles one item at a time. Most of an
// item's time goes to the shared divider, which makes four quotient bits
// per cycle: five resistance divisions of six steps and one target
// division of ten steps. A finished result waits in the output register
// while the next item is accepted. Configuration writes take effect at
// the next clock edge.
module throttle_actuator_position_control (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tapc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tapc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [tapc_pkg::TIME_W-1:0]     now_ms,
    input  logic                            clutch_pressed,
    input  logic                            brake_pressed,
    input  logic                            frame_valid,
    input  logic [tapc_pkg::CMD_W-1:0]      frame_command,
    input  logic [tapc_pkg::ADC_W-1:0]      adc_a,
    input  logic [tapc_pkg::ADC_W-1:0]      adc_b,
    input  logic [tapc_pkg::ADC_W-1:0]      adc_c,
    input  logic [tapc_pkg::ADC_W-1:0]      adc_d,
    input  logic [tapc_pkg::ADC_W-1:0]      adc_e,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            solenoid_closed,
    output logic [tapc_pkg::DIR_W-1:0]      motor_direction,
    output logic [tapc_pkg::PWM_W-1:0]      motor_pwm,
    output logic                            cancelled,
    output logic [tapc_pkg::POS_W-1:0]      position,
    output logic [tapc_pkg::POS_W-1:0]      target
);
    import tapc_pkg::*;

    tapc_cfg_t  cfg;
    tapc_cmd_t  cmd;
    tapc_stat_t stat;

    // Configuration registers.
    tapc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer.
    tapc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // Arithmetic and result register.
    tapc_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg             (cfg),
        .now_ms          (now_ms),
        .clutch_pressed  (clutch_pressed),
        .brake_pressed   (brake_pressed),
        .frame_valid     (frame_valid),
        .frame_command   (frame_command),
        .adc_a           (adc_a),
        .adc_b           (adc_b),
        .adc_c           (adc_c),
        .adc_d           (adc_d),
        .adc_e           (adc_e),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .solenoid_closed (solenoid_closed),
        .motor_direction (motor_direction),
        .motor_pwm       (motor_pwm),
        .cancelled       (cancelled),
        .position        (position),
        .target          (target)
    );

endmodule

FILE: hw/rtl/tapc_checker.sv
// ----------------------------------------------------------------------------
// Throttle actuator port checker
// Port-level assertions on the throttle actuator control block.
// ----------------------------------------------------------------------------
module tapc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       solenoid_closed,
    input logic [tapc_pkg::DIR_W-1:0] motor_direction,
    input logic [tapc_pkg::PWM_W-1:0] motor_pwm,
    input logic                       cancelled,
    input logic [tapc_pkg::POS_W-1:0] position,
    input logic [tapc_pkg::POS_W-1:0] target
);
    import tapc_pkg::*;

    // An accepted item keeps the input side stalled while it is worked on.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again right after an accepted item");

    // The solenoid state is always the inverse of the cancel flag.
    a_solenoid_cancel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (solenoid_closed != cancelled))
        else $error("solenoid state disagrees with cancel flag");

    // A cancelled tick never drives the motor.
    a_cancel_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cancelled |-> (motor_pwm == '0))
        else $error("motor driven during cancel");

    // A driven motor has a real direction.
    a_pwm_has_dir: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (motor_pwm != '0) |->
            (motor_direction == DIR_PULL) || (motor_direction == DIR_RELEASE))
        else $error("motor driven without a direction");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(target)
            && $stable(motor_pwm) && $stable(motor_direction))
        else $error("stalled result changed");

endmodule

bind throttle_actuator_position_control tapc_checker u_tapc_checker (.*);
